/* hdl/sba_pkg.sv */
`timescale 1ns / 1ps
// Package for the sensor block averager: request/result payload types,
// register indexes, fixed widths and codes. No dependencies.
package sba_pkg;

  // Fixed widths
  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 18;
  localparam int CNT_W    = 8;
  localparam int AGE_W    = 8;
  localparam int VAL_W    = 15;
  localparam int ENTRY_W  = 16;
  localparam int DIV_W    = 19;  // sum plus half the count
  localparam int DIVC_W   = 5;   // holds DIV_W
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_REPORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CODE       = 1'b1;

  // Reset values
  localparam logic [CNT_W-1:0]   SPR_RESET     = 8'd8;
  localparam logic [VAL_W-1:0]   INVALID_RESET = 15'h7fff;
  localparam logic [ENTRY_W-1:0] FILL_ENTRY    = 16'h7fff;

  // Request commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ok;
    logic                relays_on;
    logic [AGE_W-1:0]    age;
  } in_req_t;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
    logic             relay_flag;
    logic             no_valid;
  } out_res_t;

endpackage

/* hdl/sba_chan.sv */
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload of type T.
// Used with the payload structs of sba_pkg.
interface sba_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sensor_block_average_history.sv */
`timescale 1ns / 1ps
// Top level of the sensor block averager with history ring.
// Depends on sba_pkg and the sba_chan interface.
//
//  channel   dir  payload     accepted when
//  in_ch     in   in_req_t    in_ch.valid && in_ch.ready
//  out_ch    out  out_res_t   out_ch.valid && out_ch.ready
//  cfg_*     in   index/data  cfg_we high
//
// Flow: a sample inside a batch is taken in the idle state; a read passes through the
// registered ring read; a batch end goes straight to the final state with no ok sample,
// else through the one-bit-per-cycle restoring divider (19 quotient bits).
// Reset: synchronous, active low. The ring is not swept: a fill mark
// (write index plus wrapped flag) makes unwritten entries read as 0x7fff.
// Stalls: a waiting result sits in the output register while the next
// request is taken; the block holds in its final state until that slot frees.
module sensor_block_average_history
  import sba_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sba_chan.sink                in_ch,
  sba_chan.source              out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IW       = $clog2(HISTORY_DEPTH);
  localparam int AGE_SPAN = 1 << AGE_W;
  localparam logic [IW:0] DEPTH_X = (IW+1)'(HISTORY_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Configuration registers
  logic [CNT_W-1:0] spr_r;
  logic [VAL_W-1:0] inv_r;

  // Control and datapath registers
  logic [1:0]        state_r, state_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [IW-1:0]     wr_idx_r, wr_idx_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic              relay_r, relay_nxt;
  logic              unwr_r, unwr_nxt;
  logic [DIV_W-1:0]  dq_r, dq_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  drem_r, drem_nxt;
  logic [DIVC_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_r, out_nxt;

  // Ring memory
  logic [ENTRY_W-1:0] ring [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic               mem_we, mem_re;
  logic [IW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] wr_data;

  // Age modulo ring depth, worked out at elaboration
  logic [IW-1:0] age_mod [AGE_SPAN];
  for (genvar g = 0; g < AGE_SPAN; g++) begin : g_age
    assign age_mod[g] = IW'(g % HISTORY_DEPTH);
  end

  logic              in_fire, out_free;
  logic [IW:0]       rd_diff;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]  cnt_add, rem_eff, rem_dec, batch_sz;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              ge;
  logic [ENTRY_W-1:0] rd_entry;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Read address: one behind the write position, minus the age
  assign rd_diff = {1'b0, wr_idx_r} - (IW+1)'(1) - {1'b0, age_mod[in_ch.data.age]};
  assign rd_addr = rd_diff[IW] ? IW'(rd_diff + DEPTH_X) : rd_diff[IW-1:0];

  // Sample accumulation
  assign sum_add  = in_ch.data.sample_ok ?
                    sum_r + SUM_W'(in_ch.data.sample) : sum_r;
  assign cnt_add  = in_ch.data.sample_ok ? cnt_r + CNT_W'(1) : cnt_r;
  assign rem_eff  = (rem_r == '0) ? CNT_W'(1) : rem_r;
  assign rem_dec  = rem_eff - CNT_W'(1);
  assign batch_sz = (spr_r == '0) ? CNT_W'(1) : spr_r;

  // Divider step
  assign rem_sh  = {drem_r, dq_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  assign rd_entry = unwr_r ? FILL_ENTRY : rdata_r;
  assign wr_data  = {relay_r, dq_r[VAL_W-1:0]};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    wr_idx_nxt    = wr_idx_r;
    wrapped_nxt   = wrapped_r;
    relay_nxt     = relay_r;
    unwr_nxt      = unwr_r;
    dq_nxt        = dq_r;
    dvs_nxt       = dvs_r;
    drem_nxt      = drem_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.command == CMD_READ) begin
            // issue the ring read and note whether the entry was ever written
            mem_re    = 1'b1;
            unwr_nxt  = !wrapped_r && (rd_addr >= wr_idx_r);
            state_nxt = ST_READ;
          end else if (rem_dec != '0) begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_add;
            rem_nxt = rem_dec;
          end else begin
            // batch end: start the divider or report the invalid code
            relay_nxt = in_ch.data.relays_on;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            rem_nxt   = batch_sz;
            if (cnt_add == '0) begin
              dq_nxt    = DIV_W'(inv_r);
              state_nxt = ST_FIN;
            end else begin
              dq_nxt    = DIV_W'(sum_add) + DIV_W'(cnt_add >> 1);
              dvs_nxt   = cnt_add;
              drem_nxt  = '0;
              dcnt_nxt  = DIVC_W'(DIV_W);
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.kind       = KIND_READ;
          out_nxt.value      = rd_entry[VAL_W-1:0];
          out_nxt.relay_flag = rd_entry[ENTRY_W-1];
          out_nxt.no_valid   = (rd_entry[VAL_W-1:0] == inv_r);
          state_nxt          = ST_IDLE;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle
        drem_nxt = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dq_nxt   = {dq_r[DIV_W-2:0], ge};
        dcnt_nxt = dcnt_r - DIVC_W'(1);
        if (dcnt_r == DIVC_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // store the report in the ring and deliver it
        if (out_free) begin
          mem_we             = 1'b1;
          out_valid_nxt      = 1'b1;
          out_nxt.kind       = KIND_REPORT;
          out_nxt.value      = dq_r[VAL_W-1:0];
          out_nxt.relay_flag = relay_r;
          out_nxt.no_valid   = (dq_r[VAL_W-1:0] == inv_r);
          wr_idx_nxt         = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + IW'(1);
          if (wr_idx_r == LAST_IDX) begin
            wrapped_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= SPR_RESET;
      wr_idx_r    <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      spr_r       <= SPR_RESET;
      inv_r       <= INVALID_RESET;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      wr_idx_r    <= wr_idx_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
      dcnt_r      <= dcnt_nxt;
      if (cfg_we && cfg_index == CFG_SAMPLES_PER_REPORT) begin
        spr_r <= cfg_wdata[CNT_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_INVALID_CODE) begin
        inv_r <= cfg_wdata[VAL_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    relay_r <= relay_nxt;
    unwr_r  <= unwr_nxt;
    dq_r    <= dq_nxt;
    dvs_r   <= dvs_nxt;
    drem_r  <= drem_nxt;
    out_r   <= out_nxt;
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_idx_r] <= wr_data;
    end
    if (mem_re) begin
      rdata_r <= ring[rd_addr];
    end
  end

  // A stored report is the one delivered
  a_report_matches: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_valid_r && out_r.kind == KIND_REPORT &&
               out_r.value == $past(wr_data[VAL_W-1:0]) &&
               out_r.relay_flag == $past(wr_data[ENTRY_W-1]))
    else $error("ring write and report disagree");

  // The write position moves only with a ring write
  a_idx_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_we |=> $stable(wr_idx_r))
    else $error("write index moved without a ring write");

  // A read request answers with read data
  a_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && out_free) |=> out_valid_r && out_r.kind == KIND_READ)
    else $error("read result has wrong kind");

  // After its last quotient bit the divider moves to the final state
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && dcnt_r == DIVC_W'(1)) |=> state_r == ST_FIN)
    else $error("divider did not finish");

endmodule

/* tb/sba_average_checker.sv */
`timescale 1ns / 1ps
// Checker for the sensor block averager: mirrors batch averaging and the
// history ring, and compares every result taken off the result channel.
// Depends on sba_pkg.
module sba_average_checker
  import sba_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_req_t              in_req,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_res_t             out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  // Mirrored registers and averaging state
  logic [CNT_W-1:0]   batch_len;
  logic [VAL_W-1:0]   empty_code;
  logic [SUM_W-1:0]   run_sum;
  logic [CNT_W-1:0]   ok_count;
  logic [CNT_W-1:0]   batch_left;
  int                 wr_ptr;
  logic [ENTRY_W-1:0] ring [HISTORY_DEPTH];

  // Results the block still owes, oldest first
  out_res_t           owed_results [$];

  // Work out the result, if any, of one accepted request
  task automatic average_step(input in_req_t r);
    logic [ENTRY_W-1:0] entry;
    logic [DIV_W-1:0]   rounded;
    out_res_t           res;
    int                 slot;
    if (r.command == CMD_READ) begin
      slot = (wr_ptr + HISTORY_DEPTH - 1 - (int'(r.age) % HISTORY_DEPTH)) % HISTORY_DEPTH;
      entry = ring[slot];
      res.kind       = KIND_READ;
      res.value      = entry[VAL_W-1:0];
      res.relay_flag = entry[ENTRY_W-1];
      res.no_valid   = (entry[VAL_W-1:0] == empty_code);
      owed_results.push_back(res);
    end else begin
      // accumulate good conversions only
      if (r.sample_ok) begin
        run_sum  = run_sum + SUM_W'(r.sample);
        ok_count = ok_count + 1'b1;
      end
      if (batch_left == '0) batch_left = CNT_W'(1);
      batch_left = batch_left - 1'b1;
      // batch end: rounded mean, store with relay bit, start the next batch
      if (batch_left == '0) begin
        if (ok_count == '0) begin
          res.value = empty_code;
        end else begin
          rounded = (DIV_W'(run_sum) + DIV_W'(ok_count >> 1)) / DIV_W'(ok_count);
          res.value = rounded[VAL_W-1:0];
        end
        res.kind       = KIND_REPORT;
        res.relay_flag = r.relays_on;
        res.no_valid   = (res.value == empty_code);
        ring[wr_ptr] = {r.relays_on, res.value};
        wr_ptr     = (wr_ptr + 1) % HISTORY_DEPTH;
        run_sum    = '0;
        ok_count   = '0;
        batch_left = (batch_len == '0) ? CNT_W'(1) : batch_len;
        owed_results.push_back(res);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare a delivered result against the oldest owed one
  task automatic compare_result(input out_res_t got);
    out_res_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got kind %0d value %0h relay %0d nv %0d",
               $time, got.kind, got.value, got.relay_flag, got.no_valid);
      mismatches++;
    end else begin
      want = owed_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("value", want.value, got.value);
      check_field("relay_flag", want.relay_flag, got.relay_flag);
      check_field("no_valid", want.no_valid, got.no_valid);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      batch_len  = SPR_RESET;
      empty_code = INVALID_RESET;
      run_sum    = '0;
      ok_count   = '0;
      batch_left = SPR_RESET;
      wr_ptr     = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) ring[i] = FILL_ENTRY;
      owed_results.delete();
      mismatches = 0;
    end else begin
      // register writes must land only while the block is idle; nothing here enforces it
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLES_PER_REPORT: batch_len  = cfg_wdata[CNT_W-1:0];
          CFG_INVALID_CODE:       empty_code = cfg_wdata[VAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) average_step(in_req);
      if (out_valid && out_ready) compare_result(out_res);
    end
    outstanding = owed_results.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top for sensor_block_average_history: reset, clock, register
// writes, request stimulus, result back-pressure and the verdict.
// Depends on sba_pkg, sba_chan, the block and sba_average_checker.
module tb;
  import sba_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   outstanding;
  int unsigned          cycle_count = 0;
  int                   hold_left   = 0;
  bit                   calm        = 1'b1;

  sba_chan #(.T(in_req_t))  req_if ();
  sba_chan #(.T(out_res_t)) res_if ();

  sensor_block_average_history dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sba_average_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req_if.valid),
    .in_ready    (req_if.ready),
    .in_req      (req_if.data),
    .out_valid   (res_if.valid),
    .out_ready   (res_if.ready),
    .out_res     (res_if.data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long; none in calm phases
  function automatic int pick_pause();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      hold_left = pick_pause();
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic in_req_t sample_req(input logic [SAMPLE_W-1:0] s, input logic ok,
                                         input logic relay);
    in_req_t r;
    r.command   = CMD_SAMPLE;
    r.sample    = s;
    r.sample_ok = ok;
    r.relays_on = relay;
    r.age       = AGE_W'($urandom_range(0, 255));
    return r;
  endfunction

  // Read request; the sample fields carry junk the block must ignore
  function automatic in_req_t read_req(input logic [AGE_W-1:0] age);
    in_req_t r;
    r.command   = CMD_READ;
    r.sample    = SAMPLE_W'($urandom_range(0, 1023));
    r.sample_ok = 1'($urandom_range(0, 1));
    r.relays_on = 1'($urandom_range(0, 1));
    r.age       = age;
    return r;
  endfunction

  // Offer one request after an optional gap and hold it until accepted
  task automatic send(input in_req_t r);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid, wait for every owed result, then let the block go idle
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                  phase;
    int                  sent;
    int                  n;
    int                  ok_pct;
    int                  read_pct;
    int                  roll;
    bit                  full_scale;
    logic [CNT_W-1:0]    spr;
    logic [VAL_W-1:0]    code;
    logic [SAMPLE_W-1:0] s;

    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SAMPLES_PER_REPORT;
    cfg_wdata    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset fill, at both ends of the ring
    send(read_req(8'd0));
    send(read_req(8'd255));
    // full-scale batch at the reset size, relay on
    repeat (8) send(sample_req(10'h3ff, 1'b1, 1'b1));
    // newest entry, then one never written
    send(read_req(8'd0));
    send(read_req(8'd1));
    settle();

    // zero batch size acts as one; invalid code at its low end
    write_reg(CFG_SAMPLES_PER_REPORT, {7'h7f, 8'd0});
    write_reg(CFG_INVALID_CODE, '0);
    send(sample_req(10'h000, 1'b1, 1'b0));
    send(sample_req(10'h2aa, 1'b0, 1'b1));
    // a slot never written still reads as the fill value
    send(read_req(8'd3));
    settle();

    // a new size waits for the running batch to end
    write_reg(CFG_SAMPLES_PER_REPORT, CFG_W'(3));
    send(sample_req(10'h155, 1'b1, 1'b0));
    send(sample_req(10'h001, 1'b1, 1'b0));
    send(sample_req(10'h002, 1'b1, 1'b1));
    settle();
    write_reg(CFG_SAMPLES_PER_REPORT, CFG_W'(2));
    send(sample_req(10'h002, 1'b1, 1'b1));
    send(sample_req(10'h001, 1'b1, 1'b0));
    send(sample_req(10'h002, 1'b1, 1'b0));

    // random phases, each under its own register setting
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      full_scale = (phase == 0);
      if (phase == 0) begin
        spr  = 8'd255;
        code = 15'h7fff;
      end else begin
        case ($urandom_range(0, 9))
          0:       spr = 8'd1;
          1:       spr = 8'd255;
          2:       spr = 8'd0;
          3, 4, 5: spr = CNT_W'($urandom_range(2, 4));
          default: spr = CNT_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 5))
          0:       code = '0;
          1:       code = 15'h7fff;
          2, 3:    code = VAL_W'($urandom_range(0, 1023));
          default: code = VAL_W'($urandom_range(0, 32767));
        endcase
      end
      write_reg(CFG_SAMPLES_PER_REPORT, {7'($urandom_range(0, 127)), spr});
      write_reg(CFG_INVALID_CODE, code);

      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       ok_pct = 0;
        1:       ok_pct = 100;
        default: ok_pct = $urandom_range(30, 95);
      endcase
      if (full_scale) ok_pct = 100;
      read_pct = $urandom_range(10, 25);
      if (spr == 8'd255) n = 320;
      else if (spr <= 8'd1) n = $urandom_range(30, 80);
      else n = $urandom_range(60, 160);

      repeat (n) begin
        if ($urandom_range(0, 99) < read_pct) begin
          send(read_req($urandom_range(0, 3) == 0 ? AGE_W'($urandom_range(0, 255))
                                                  : AGE_W'($urandom_range(0, 9))));
        end else begin
          roll = $urandom_range(0, 9);
          if (full_scale || roll == 0) s = '1;
          else if (roll == 1) s = '0;
          else s = SAMPLE_W'($urandom_range(0, 1023));
          send(sample_req(s, $urandom_range(0, 99) < ok_pct, 1'($urandom_range(0, 1))));
        end
        sent++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
hdl/sba_pkg.sv
hdl/sba_chan.sv
hdl/sensor_block_average_history.sv
tb/sba_average_checker.sv
tb/tb.sv
